[hw/rtl/periodic_task_release_scheduler_assert.svh]
// Assertion macros for the periodic task release scheduler.
// Used by the top level; needs clk and rst_n in scope.
`ifndef PERIODIC_TASK_RELEASE_SCHEDULER_ASSERT_SVH
`define PERIODIC_TASK_RELEASE_SCHEDULER_ASSERT_SVH

// Property checked on every clock edge, off while in reset.
`define PTRS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen on a clock edge outside reset.
`define PTRS_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[hw/rtl/ptrs_pkg.sv]
// Shared widths and command codes for the periodic task release scheduler.
// No dependencies.
package ptrs_pkg;

    localparam int CMD_W   = 2;
    localparam int SLOT_W  = 3;
    localparam int TICK_W  = 16;
    localparam int MASK_W  = 8;

    typedef logic [CMD_W-1:0]  cmd_t;
    typedef logic [TICK_W-1:0] tick_t;
    typedef logic [MASK_W-1:0] mask_t;

    localparam cmd_t CMD_TICK   = 2'd0;
    localparam cmd_t CMD_CREATE = 2'd1;
    localparam cmd_t CMD_MODIFY = 2'd2;

endpackage

[hw/rtl/ptrs_if.sv]
// Request and response channel interfaces of the task release scheduler.
// Depends on ptrs_pkg.
interface ptrs_req_if
    import ptrs_pkg::*;
    ();
    logic                valid;
    logic                ready;
    cmd_t                cmd;
    logic [SLOT_W-1:0]   slot;
    tick_t               period;
    tick_t               first_delay;
    logic                enabled;

    modport source (output valid, cmd, slot, period, first_delay, enabled, input ready);
    modport sink   (input valid, cmd, slot, period, first_delay, enabled, output ready);
endinterface

interface ptrs_rsp_if
    import ptrs_pkg::*;
    ();
    logic  valid;
    logic  ready;
    mask_t due_mask;
    tick_t tick_count;

    modport source (output valid, due_mask, tick_count, input ready);
    modport sink   (input valid, due_mask, tick_count, output ready);
endinterface

[hw/rtl/periodic_task_release_scheduler.sv]
// Create/modify go straight to S_DONE. A tick walks the slots in S_SCAN; a delayed slot
// counts its delay down, a disabled or zero-period slot is passed over, and any other slot
// goes through the modulo unit (S_DIV). One request at a time; a response waits in S_DONE.
// The single bit-serial modulo unit, shared across slots, sets the tick time.
// Reset (async, active low) clears tick counter and all slot tables; no clearing pass.
module periodic_task_release_scheduler
    import ptrs_pkg::*;
#(
    parameter int TASK_SLOTS = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    ptrs_req_if.sink  req,
    ptrs_rsp_if.source rsp
);

`include "periodic_task_release_scheduler_assert.svh"

    localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(TASK_SLOTS - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    tick_t         tick_reg, tick_next;
    mask_t         mask_reg, mask_next;
    tick_t         rem_reg, rem_next;
    tick_t         divisor_reg, divisor_next;
    tick_t         dividend_reg, dividend_next;
    logic [3:0]    bit_reg, bit_next;

    tick_t         period_reg  [TASK_SLOTS];
    tick_t         period_next [TASK_SLOTS];
    tick_t         delay_reg   [TASK_SLOTS];
    tick_t         delay_next  [TASK_SLOTS];
    logic          en_reg      [TASK_SLOTS];
    logic          en_next     [TASK_SLOTS];

    logic          out_valid_reg, out_valid_next;
    mask_t         out_mask_reg, out_mask_next;
    tick_t         out_tick_reg, out_tick_next;

    logic          accept;
    logic          slot_ok;
    logic [IW-1:0] wr_idx;
    logic [TICK_W:0] trial;
    logic [TICK_W:0] trial_sub;
    tick_t         rem_step;
    logic          load_out;

    assign accept  = req.valid && req.ready;
    assign slot_ok = (32'(req.slot) < 32'(TASK_SLOTS));
    assign wr_idx  = IW'(req.slot);

    // one restoring step of tick % period
    assign trial     = {rem_reg, dividend_reg[TICK_W-1]};
    assign trial_sub = trial - {1'b0, divisor_reg};
    assign rem_step  = trial_sub[TICK_W] ? trial[TICK_W-1:0] : trial_sub[TICK_W-1:0];

    assign load_out  = (state_reg == S_DONE) && (!out_valid_reg || rsp.ready);

    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.due_mask   = out_mask_reg;
    assign rsp.tick_count = out_tick_reg;

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        tick_next     = tick_reg;
        mask_next     = mask_reg;
        rem_next      = rem_reg;
        divisor_next  = divisor_reg;
        dividend_next = dividend_reg;
        bit_next      = bit_reg;
        period_next   = period_reg;
        delay_next    = delay_reg;
        en_next       = en_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    mask_next = '0;
                    idx_next  = '0;
                    state_next = S_DONE;
                    case (req.cmd)
                        CMD_TICK:
                        begin
                            tick_next  = tick_reg + 16'd1;
                            state_next = S_SCAN;
                        end
                        CMD_CREATE:
                        begin
                            if (slot_ok)
                            begin
                                period_next[wr_idx] = req.period;
                                delay_next[wr_idx]  = req.first_delay;
                                en_next[wr_idx]     = req.enabled;
                            end
                        end
                        CMD_MODIFY:
                        begin
                            if (slot_ok)
                            begin
                                period_next[wr_idx] = req.period;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (delay_reg[idx_reg] != '0)
                begin
                    delay_next[idx_reg] = delay_reg[idx_reg] - 16'd1;
                    state_next = (idx_reg == LAST_IDX) ? S_DONE : S_SCAN;
                    idx_next   = idx_reg + 1'b1;
                end
                else if (en_reg[idx_reg] && (period_reg[idx_reg] != '0))
                begin
                    rem_next      = '0;
                    divisor_next  = period_reg[idx_reg];
                    dividend_next = tick_reg;
                    bit_next      = 4'd15;
                    state_next    = S_DIV;
                end
                else
                begin
                    state_next = (idx_reg == LAST_IDX) ? S_DONE : S_SCAN;
                    idx_next   = idx_reg + 1'b1;
                end
            end
            S_DIV:
            begin
                rem_next      = rem_step;
                dividend_next = {dividend_reg[TICK_W-2:0], 1'b0};
                bit_next      = bit_reg - 4'd1;
                if (bit_reg == 4'd0)
                begin
                    // slots beyond the mask width shift out of the 8-bit result
                    if (rem_step == '0)
                    begin
                        mask_next = mask_reg | (mask_t'(1) << idx_reg);
                    end
                    state_next = (idx_reg == LAST_IDX) ? S_DONE : S_SCAN;
                    idx_next   = idx_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_mask_next  = out_mask_reg;
        out_tick_next  = out_tick_reg;
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_mask_next  = mask_reg;
            out_tick_next  = tick_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            tick_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < TASK_SLOTS; i++)
            begin
                period_reg[i] <= '0;
                delay_reg[i]  <= '0;
                en_reg[i]     <= 1'b0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            tick_reg      <= tick_next;
            out_valid_reg <= out_valid_next;
            period_reg    <= period_next;
            delay_reg     <= delay_next;
            en_reg        <= en_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mask_reg     <= mask_next;
        rem_reg      <= rem_next;
        divisor_reg  <= divisor_next;
        dividend_reg <= dividend_next;
        bit_reg      <= bit_next;
        out_mask_reg <= out_mask_next;
        out_tick_reg <= out_tick_next;
    end

    `PTRS_ASSERT(a_tick_incr, (accept && (req.cmd == CMD_TICK)) |=> (tick_reg == 16'($past(tick_reg) + 16'd1)), "tick counter did not advance on tick request")
    `PTRS_ASSERT(a_tick_hold, (accept && (req.cmd != CMD_TICK)) |=> (tick_reg == $past(tick_reg)), "tick counter moved on a non-tick request")
    `PTRS_ASSERT(a_rem_bound, (state_reg == S_DIV) |-> ((divisor_reg != '0) && (rem_reg < divisor_reg)), "modulo remainder out of range")
    `PTRS_NEVER(a_load_clobber, load_out && out_valid_reg && !rsp.ready, "pending response overwritten")

endmodule
